// ===== rtl/core/dssra_pkg.sv =====
// Shared widths, register indexes and reset values for the
// dual-screen rotate/scale address generator. No dependencies.
`default_nettype none

package dssra_pkg;

  // Field widths
  localparam int unsigned DIM_W  = 11;  // screen dimensions
  localparam int unsigned SRC_W  = 13;  // source frame dimensions
  localparam int unsigned HALF_W = 12;  // half source height
  localparam int unsigned PB_W   = 3;   // bytes per pixel
  localparam int unsigned COORD_W = 10; // destination coordinates
  localparam int unsigned SOFF_W = 27;  // source byte offset
  localparam int unsigned DOFF_W = 23;  // destination byte offset

  // Divider geometry: numerator x*source_width, divisor a screen dimension
  localparam int unsigned NUM_W = COORD_W + SRC_W;
  localparam int unsigned DIV_W = DIM_W;
  localparam int unsigned QUO_W = SRC_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SRC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES   = 3'd5;

  localparam logic [DIM_W-1:0] RST_TOP_WIDTH     = 11'd400;
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 11'd240;
  localparam logic [DIM_W-1:0] RST_BOTTOM_WIDTH  = 11'd320;
  localparam logic [SRC_W-1:0] RST_SOURCE_WIDTH  = 13'd800;
  localparam logic [SRC_W-1:0] RST_SOURCE_HEIGHT = 13'd480;
  localparam logic [PB_W-1:0]  RST_PIXEL_BYTES   = 3'd3;

endpackage

`default_nettype wire

// ===== rtl/core/dssra_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dssra_pkg for widths; stage enables come from the caller.
`default_nettype none

module dssra_div
  import dssra_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [QUO_W-1:0] en,
  input  wire logic [NUM_W-1:0] num_in,
  input  wire logic [DIV_W-1:0] den_in,
  output logic      [QUO_W-1:0] quo_out
);

  // Caller guarantees num < den << QUO_W for meaningful results.
  logic [NUM_W-1:0] rem_r [QUO_W-1];
  logic [DIV_W-1:0] den_r [QUO_W-1];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0] rem_prev;
    logic [DIV_W-1:0] den_prev;
    logic [QUO_W-1:0] quo_prev;
    logic [NUM_W:0]   trial;
    logic             ge;
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_prev = num_in;
      assign den_prev = den_in;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign den_prev = den_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    always_comb begin
      trial   = (NUM_W+1)'(den_prev) << (QUO_W - 1 - k);
      ge      = {1'b0, rem_prev} >= trial;
      rem_nxt = ge ? rem_prev - trial[NUM_W-1:0] : rem_prev;
      quo_nxt = {quo_prev[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= quo_nxt;
      end
    end

    if (k < QUO_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_prev;
        end
      end
    end
  end

  assign quo_out = quo_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/dual_screen_rotate_scale_address.sv =====
// Top level of the dual-screen rotate/scale address generator.
// Depends on dssra_pkg and dssra_div.
`default_nettype none

//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------
//  in_     | sink      | dest_x, dest_y, screen_sel
//  out_    | source    | source_offset, dest_offset, out_of_range
//  cfg_    | sink      | write enable, register index, write data (no ready)
//
//  One beat in per cycle unless an output stall backs up to the entry stage; two entry
//  stages, the 13-stage divider pipelines for column and row, and three tail stages.
//  Synchronous active-low reset clears the valid bits and loads the register
//  reset values. Each stage holds only if it is full and its successor holds,
//  so bubbles collapse and a stalled output does not block entry to emptier
//  stages.

module dual_screen_rotate_scale_address
  import dssra_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_W-1:0]    in_dest_x,
  input  wire logic [COORD_W-1:0]    in_dest_y,
  input  wire logic                  in_screen_sel,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [SOFF_W-1:0]     out_source_offset,
  output logic      [DOFF_W-1:0]     out_dest_offset,
  output logic                       out_out_of_range,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ST_S1   = 0;
  localparam int unsigned ST_S2   = 1;
  localparam int unsigned ST_DIV0 = 2;
  localparam int unsigned ST_T1   = ST_DIV0 + QUO_W;
  localparam int unsigned ST_T2   = ST_T1 + 1;
  localparam int unsigned ST_OUT  = ST_T2 + 1;
  localparam int unsigned STAGES  = ST_OUT + 1;

  // Configuration registers
  logic [DIM_W-1:0] top_width_r, screen_height_r, bottom_width_r;
  logic [SRC_W-1:0] source_width_r, source_height_r;
  logic [PB_W-1:0]  pixel_bytes_r;
  logic [HALF_W-1:0] half_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_width_r     <= RST_TOP_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      bottom_width_r  <= RST_BOTTOM_WIDTH;
      source_width_r  <= RST_SOURCE_WIDTH;
      source_height_r <= RST_SOURCE_HEIGHT;
      pixel_bytes_r   <= RST_PIXEL_BYTES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOP_WIDTH:     top_width_r     <= cfg_wdata[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_BOTTOM_WIDTH:  bottom_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_wdata[SRC_W-1:0];
        CFG_PIXEL_BYTES:   pixel_bytes_r   <= cfg_wdata[PB_W-1:0];
        default: ;
      endcase
    end
  end

  assign half_h = source_height_r[SRC_W-1:1];

  // Valid bits and per-stage load enables
  logic [STAGES-1:0] v_r;
  logic [STAGES:0]   rdy;

  always_comb begin
    rdy[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[i-1];
        end
      end
    end
  end

  assign in_ready  = rdy[ST_S1];
  assign out_valid = v_r[ST_OUT];

  // S1: capture beat, range check
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic               s1_sel_r, s1_oor_r;
  logic [DIM_W-1:0]   in_width;

  assign in_width = in_screen_sel ? bottom_width_r : top_width_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_S1]) begin
      s1_x_r   <= in_dest_x;
      s1_y_r   <= in_dest_y;
      s1_sel_r <= in_screen_sel;
      s1_oor_r <= (DIM_W'(in_dest_x) >= in_width) || (DIM_W'(in_dest_y) >= screen_height_r);
    end
  end

  // S2: numerators and unscaled rotated destination index
  logic [NUM_W-1:0]  s2_ncol_r;
  logic [NUM_W-1:0]  s2_nrow_r;
  logic [DOFF_W-1:0] s2_dsum_r;
  logic [DIV_W-1:0]  s2_den_r;
  logic              s2_sel_r, s2_oor_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_S2]) begin
      s2_ncol_r <= NUM_W'(s1_x_r) * NUM_W'(source_width_r);
      s2_nrow_r <= NUM_W'(s1_y_r) * NUM_W'(half_h);
      // (h - y - 1) + h * x, column-major with y flipped
      s2_dsum_r <= DOFF_W'(screen_height_r) - DOFF_W'(s1_y_r) - DOFF_W'(1)
                 + DOFF_W'(screen_height_r) * DOFF_W'(s1_x_r);
      s2_den_r  <= s1_sel_r ? bottom_width_r : top_width_r;
      s2_sel_r  <= s1_sel_r;
      s2_oor_r  <= s1_oor_r;
    end
  end

  // Divider stages: column and row quotients in parallel
  logic [QUO_W-1:0] col_q, row_q;

  dssra_div u_div_col (
    .clk     (clk),
    .en      (rdy[ST_DIV0 +: QUO_W]),
    .num_in  (s2_ncol_r),
    .den_in  (s2_den_r),
    .quo_out (col_q)
  );

  dssra_div u_div_row (
    .clk     (clk),
    .en      (rdy[ST_DIV0 +: QUO_W]),
    .num_in  (s2_nrow_r),
    .den_in  (screen_height_r),
    .quo_out (row_q)
  );

  // Side data riding alongside the dividers; destination scaled in the first
  logic              dv_sel_r [QUO_W];
  logic              dv_oor_r [QUO_W];
  logic [DOFF_W-1:0] dv_dst_r [QUO_W];

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (rdy[ST_DIV0 + k]) begin
        if (k == 0) begin
          dv_sel_r[k] <= s2_sel_r;
          dv_oor_r[k] <= s2_oor_r;
          dv_dst_r[k] <= DOFF_W'(s2_dsum_r * DOFF_W'(pixel_bytes_r));
        end else begin
          dv_sel_r[k] <= dv_sel_r[k-1];
          dv_oor_r[k] <= dv_oor_r[k-1];
          dv_dst_r[k] <= dv_dst_r[k-1];
        end
      end
    end
  end

  // T1: source row times source width
  logic [QUO_W-1:0]   t1_col_r;
  logic [2*SRC_W-1:0] t1_rs_r;
  logic [DOFF_W-1:0]  t1_dst_r;
  logic               t1_oor_r;
  logic [SRC_W-1:0]   row;

  // bottom screen samples the lower half of the source
  assign row = SRC_W'(row_q) + (dv_sel_r[QUO_W-1] ? SRC_W'(half_h) : '0);

  always_ff @(posedge clk) begin
    if (rdy[ST_T1]) begin
      t1_col_r <= col_q;
      t1_rs_r  <= (2*SRC_W)'(row) * (2*SRC_W)'(source_width_r);
      t1_dst_r <= dv_dst_r[QUO_W-1];
      t1_oor_r <= dv_oor_r[QUO_W-1];
    end
  end

  // T2: pixel index
  logic [SOFF_W-1:0] t2_sum_r;
  logic [DOFF_W-1:0] t2_dst_r;
  logic              t2_oor_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_T2]) begin
      t2_sum_r <= SOFF_W'(t1_col_r) + SOFF_W'(t1_rs_r);
      t2_dst_r <= t1_dst_r;
      t2_oor_r <= t1_oor_r;
    end
  end

  // Output register: byte scaling, zero offsets when out of range
  logic [SOFF_W-1:0] out_src_r;
  logic [DOFF_W-1:0] out_dst_r;
  logic              out_oor_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_src_r <= t2_oor_r ? '0 : SOFF_W'(t2_sum_r * SOFF_W'(pixel_bytes_r));
      out_dst_r <= t2_oor_r ? '0 : t2_dst_r;
      out_oor_r <= t2_oor_r;
    end
  end

  assign out_source_offset = out_src_r;
  assign out_dest_offset   = out_dst_r;
  assign out_out_of_range  = out_oor_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_dual_screen_rotate_scale_address.sv =====
// Self-checking testbench for dual_screen_rotate_scale_address: random coordinates under
// several register settings, with results checked against an in-bench offset predictor.
// Depends on dssra_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_dual_screen_rotate_scale_address
  import dssra_pkg::*;
();

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned ITEMS_PHASE  = 180;
  localparam int unsigned STEADY_BEATS = 40;

  typedef struct packed {
    logic [SOFF_W-1:0] source_offset;
    logic [DOFF_W-1:0] dest_offset;
    logic              out_of_range;
  } offsets_t;

  class offset_scoreboard;
    logic [DIM_W-1:0] top_width;
    logic [DIM_W-1:0] screen_height;
    logic [DIM_W-1:0] bottom_width;
    logic [SRC_W-1:0] source_width;
    logic [SRC_W-1:0] source_height;
    logic [PB_W-1:0]  pixel_bytes;
    offsets_t         expected_offsets[$];
    int unsigned      mismatches;

    function new();
      top_width     = RST_TOP_WIDTH;
      screen_height = RST_SCREEN_HEIGHT;
      bottom_width  = RST_BOTTOM_WIDTH;
      source_width  = RST_SOURCE_WIDTH;
      source_height = RST_SOURCE_HEIGHT;
      pixel_bytes   = RST_PIXEL_BYTES;
      mismatches    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TOP_WIDTH:     top_width     = val[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height = val[DIM_W-1:0];
        CFG_BOTTOM_WIDTH:  bottom_width  = val[DIM_W-1:0];
        CFG_SOURCE_WIDTH:  source_width  = val[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: source_height = val[SRC_W-1:0];
        CFG_PIXEL_BYTES:   pixel_bytes   = val[PB_W-1:0];
        default: ;
      endcase
    endfunction

    function offsets_t predict_offsets(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                       logic bottom);
      offsets_t        r;
      longint unsigned xv, yv, w, h, sw, pb, half, col, row, src, dst;
      xv   = x;
      yv   = y;
      w    = bottom ? bottom_width : top_width;
      h    = screen_height;
      sw   = source_width;
      pb   = pixel_bytes;
      half = source_height / 2;
      r    = '0;
      if (xv >= w || yv >= h) begin
        r.out_of_range = 1'b1;
        return r;
      end
      col = (xv * sw) / w;
      row = (yv * half) / h;
      // bottom screen samples the lower half of the source frame
      if (bottom) row += half;
      src = (col + row * sw) * pb;
      // rotated buffer: column-major with y flipped
      dst = ((h - yv - 1) + h * xv) * pb;
      r.source_offset = SOFF_W'(src);
      r.dest_offset   = DOFF_W'(dst);
      return r;
    endfunction

    function void note_coordinate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic bottom);
      expected_offsets.push_back(predict_offsets(x, y, bottom));
    endfunction

    function void check_offsets(logic [SOFF_W-1:0] src, logic [DOFF_W-1:0] dst, logic oor);
      offsets_t e;
      if (expected_offsets.size() == 0) begin
        $error("result beat with nothing expected: source_offset %0d dest_offset %0d",
               src, dst);
        mismatches++;
        return;
      end
      e = expected_offsets.pop_front();
      if (src !== e.source_offset) begin
        $error("source_offset: expected %0d, actual %0d", e.source_offset, src);
        mismatches++;
      end
      if (dst !== e.dest_offset) begin
        $error("dest_offset: expected %0d, actual %0d", e.dest_offset, dst);
        mismatches++;
      end
      if (oor !== e.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", e.out_of_range, oor);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_offsets.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [COORD_W-1:0]    in_dest_x;
  logic [COORD_W-1:0]    in_dest_y;
  logic                  in_screen_sel;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SOFF_W-1:0]     out_source_offset;
  logic [DOFF_W-1:0]     out_dest_offset;
  logic                  out_out_of_range;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  offset_scoreboard sb = new();
  int unsigned      ready_hold = 0;
  int unsigned      idle_cycles = 0;

  dual_screen_rotate_scale_address u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_dest_x         (in_dest_x),
    .in_dest_y         (in_dest_y),
    .in_screen_sel     (in_screen_sel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_source_offset (out_source_offset),
    .out_dest_offset   (out_dest_offset),
    .out_out_of_range  (out_out_of_range),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure: hold each ready level for a random stretch
  always @(posedge clk) begin
    int unsigned r;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold == 0) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(1, 8);
      end else if (r < 62) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(40, 120);
      end else if (r < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(1, 3);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_coordinate(in_dest_x, in_dest_y, in_screen_sel);
      if (out_valid && out_ready)
        sb.check_offsets(out_source_offset, out_dest_offset, out_out_of_range);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly in range, some on the boundary, a little pure noise
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
    int unsigned r, v;
    r = $urandom_range(0, 99);
    if (lim == 0 || r >= 92) return COORD_W'($urandom_range(0, 1023));
    if (r >= 78) begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = lim - 1;
        2:       v = lim;
        default: v = lim + 1;
      endcase
      return (v > 1023) ? COORD_W'(1023) : COORD_W'(v);
    end
    return COORD_W'($urandom_range(0, ((lim > 1024) ? 1024 : lim) - 1));
  endfunction

  task automatic send_beat(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic bottom, input int unsigned gap);
    in_valid      <= 1'b1;
    in_dest_x     <= x;
    in_dest_y     <= y;
    in_screen_sel <= bottom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned tw, input int unsigned sh,
                              input int unsigned bw, input int unsigned sw,
                              input int unsigned sht, input int unsigned pb);
    logic [CFG_IDX_W-1:0]  idx[6];
    logic [CFG_DATA_W-1:0] val[6];
    idx[0] = CFG_TOP_WIDTH;     val[0] = CFG_DATA_W'(tw);
    idx[1] = CFG_SCREEN_HEIGHT; val[1] = CFG_DATA_W'(sh);
    idx[2] = CFG_BOTTOM_WIDTH;  val[2] = CFG_DATA_W'(bw);
    idx[3] = CFG_SOURCE_WIDTH;  val[3] = CFG_DATA_W'(sw);
    idx[4] = CFG_SOURCE_HEIGHT; val[4] = CFG_DATA_W'(sht);
    idx[5] = CFG_PIXEL_BYTES;   val[5] = CFG_DATA_W'(pb);
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      sb.set_register(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int unsigned n);
    logic bottom;
    int unsigned w;
    for (int unsigned i = 0; i < n; i++) begin
      bottom = 1'($urandom_range(0, 1));
      w = bottom ? sb.bottom_width : sb.top_width;
      send_beat(pick_coord(w), pick_coord(sb.screen_height), bottom,
                (i < STEADY_BEATS) ? 0 : pick_gap());
    end
    drain();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_dest_x     = '0;
    in_dest_y     = '0;
    in_screen_sel = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_TOP_WIDTH;
    cfg_wdata     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners and boundaries under the reset geometry, both screens
    send_beat(0, 0, 1'b0, pick_gap());
    send_beat(399, 239, 1'b0, pick_gap());
    send_beat(400, 0, 1'b0, pick_gap());
    send_beat(0, 240, 1'b0, pick_gap());
    send_beat(200, 120, 1'b0, pick_gap());
    send_beat(0, 0, 1'b1, pick_gap());
    send_beat(319, 239, 1'b1, pick_gap());
    send_beat(320, 0, 1'b1, pick_gap());
    send_beat(399, 100, 1'b1, pick_gap());
    send_beat(160, 120, 1'b1, pick_gap());
    send_beat(1023, 1023, 1'b0, pick_gap());
    send_beat(1023, 1023, 1'b1, pick_gap());
    send_beat(0, 1023, 1'b0, pick_gap());
    send_beat(1023, 0, 1'b1, 0);
    run_random(ITEMS_PHASE);

    apply_config(1024, 1024, 1024, 4096, 4096, 4);
    run_random(ITEMS_PHASE);
    apply_config(1, 1, 1, 1, 2, 1);
    run_random(ITEMS_PHASE);
    // field maxima: products overflow and wrap
    apply_config(2047, 2047, 2047, 8191, 8191, 7);
    run_random(ITEMS_PHASE);
    // zero top width, zero source width and pixel size, odd source height
    apply_config(0, 240, 320, 0, 481, 0);
    run_random(ITEMS_PHASE);
    // zero height: every coordinate lands outside
    apply_config(400, 0, 320, 800, 480, 3);
    run_random(ITEMS_PHASE);
    apply_config($urandom_range(1, 1024), $urandom_range(1, 1024), $urandom_range(1, 1024),
                 $urandom_range(1, 4096), $urandom_range(2, 4096), $urandom_range(1, 4));
    run_random(ITEMS_PHASE);
    apply_config($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                 $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 7));
    run_random(ITEMS_PHASE);

    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.outstanding() != 0) $error("%0d results never arrived", sb.outstanding());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
